>>> rtl/core/fps_pkg.sv
package fps_pkg;

    // register map, index taken from paddr[3:2]
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_IDENT  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FOOTER = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MAC    = 2'd2;

    // reset values: identifier is "4649", first character in the low byte
    localparam logic [31:0] IDENT_RESET  = 32'h3934_3634;
    localparam logic [7:0]  FOOTER_RESET = 8'h20;
    localparam logic [7:0]  MAC_RESET    = 8'h20;

    // status codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_IDENT = 2'd1;
    localparam logic [1:0] ERR_SEQ   = 2'd2;
    localparam logic [1:0] ERR_VER   = 2'd3;

    // segment header layout
    localparam logic [4:0] HDR_LEN      = 5'd16;
    localparam logic [4:0] HDR_IDX_LEN  = 5'd4;
    localparam logic [4:0] HDR_IDX_CUR  = 5'd8;
    localparam logic [4:0] HDR_IDX_TOT  = 5'd10;
    localparam logic [4:0] HDR_IDX_END  = 5'd12;
    localparam logic [4:0] HDR_IDX_MAC  = 5'd13;
    localparam logic [4:0] HDR_IDX_PRE  = 5'd14;
    localparam logic [4:0] HDR_IDX_LAST = 5'd15;

    // version digits occupy stream positions 48..63
    localparam int VER_FIRST = 48;
    localparam int VER_LAST  = 63;
    localparam logic [7:0] ASCII_0 = 8'h30;
    localparam logic [7:0] ASCII_9 = 8'h39;

    localparam int OUT_SIZE_W = 40;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        logic [31:0] ident;
        logic [7:0]  footer;
        logic [7:0]  mac_ext;
    } t_cfg;

    typedef struct packed {
        logic [7:0]            data_out;
        logic                  to_info_file;
        logic [1:0]            status;
        logic                  is_version_char;
        logic                  headers_done;
        logic [OUT_SIZE_W-1:0] package_size;
    } t_result;

endpackage

>>> rtl/core/firmware_package_stream_splitter.sv
// firmware package stream splitter
//
// input channel: one package byte per beat on i_data_byte, taken when push
//   is high and full is low. every beat yields exactly one result beat
// result channel: while empty is low the oldest result sits on the o_ ports
//   (byte, destination, status, version flag, headers done, package size);
//   it is taken when pop is high and empty is low
// config: apb-style port, registers at byte address 0 (identifier),
//   4 (footer length), 8 (mac extension length); pready is tied high,
//   writes land on the access cycle, reads return the register value
// result path: the front is combinational, the result queue is the only
//   register; from an empty queue, empty goes low in the cycle after push
// throughput: one byte per cycle while full is low; the parser updates all
//   its counters for each byte as it is taken, so push can stay high
// stalls: a four-beat result queue sits between the parser and the result
//   ports; when pop stays low it fills and full rises, holding off push
// reset: i_rst_n is synchronous, active low; it clears the queue, the parser
//   state except r_len16, and sticky error; loads default register values
module firmware_package_stream_splitter #(
    parameter int SIZE_BITS = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,

    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_data_out,
    output logic        o_to_info_file,
    output logic [1:0]  o_status,
    output logic        o_is_version_char,
    output logic        o_headers_done,
    output logic [39:0] o_package_size,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    fps_pkg::t_cfg    r_cfg;
    fps_pkg::t_result front_result;
    fps_pkg::t_result head;

    logic                            in_accept;
    logic                            cfg_wr;
    logic [fps_pkg::REG_IDX_W-1:0]   reg_idx;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign in_accept = push && !full;

    // register file; user must write only between packages, not enforced
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ident   <= fps_pkg::IDENT_RESET;
            r_cfg.footer  <= fps_pkg::FOOTER_RESET;
            r_cfg.mac_ext <= fps_pkg::MAC_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                fps_pkg::REG_IDENT:  r_cfg.ident   <= pwdata;
                fps_pkg::REG_FOOTER: r_cfg.footer  <= pwdata[7:0];
                fps_pkg::REG_MAC:    r_cfg.mac_ext <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            fps_pkg::REG_IDENT:  prdata = r_cfg.ident;
            fps_pkg::REG_FOOTER: prdata = {24'd0, r_cfg.footer};
            fps_pkg::REG_MAC:    prdata = {24'd0, r_cfg.mac_ext};
            default:             prdata = 32'd0;
        endcase
    end

    // front: header parse, skip counting, routing and error tracking per beat
    fps_front #(
        .SIZE_BITS (SIZE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_data_byte),
        .i_cfg    (r_cfg),
        .o_result (front_result)
    );

    // back: result queue decouples the parser from the consumer
    fps_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (in_accept),
        .i_wdata (front_result),
        .i_rd    (pop),
        .o_rdata (head),
        .o_full  (full),
        .o_empty (empty)
    );

    assign o_data_out        = head.data_out;
    assign o_to_info_file    = head.to_info_file;
    assign o_status          = head.status;
    assign o_is_version_char = head.is_version_char;
    assign o_headers_done    = head.headers_done;
    assign o_package_size    = head.package_size;

endmodule

>>> rtl/core/fps_front.sv
module fps_front #(
    parameter int SIZE_BITS = 40
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    input  fps_pkg::t_cfg    i_cfg,
    output fps_pkg::t_result o_result
);

    localparam int SW   = SIZE_BITS;
    localparam int SUMW = SIZE_BITS + 3;
    localparam int OW   = fps_pkg::OUT_SIZE_W;
    localparam int WW   = (SW > OW) ? SW : OW;
    localparam logic [SW-1:0] SIZE_MAX = {SW{1'b1}};
    localparam logic [OW-1:0] OUT_MAX  = {OW{1'b1}};

    logic [33:0]   r_skip, n_skip;
    logic [4:0]    r_idx, n_idx;
    logic [31:0]   r_ident, n_ident;
    logic [31:0]   r_length, n_length;
    logic [15:0]   r_cur, n_cur;
    logic [15:0]   r_tot, n_tot;
    logic          r_mac, n_mac;
    logic [32:0]   r_len16, n_len16;
    logic [15:0]   r_seen, n_seen;
    logic          r_all, n_all;
    logic [SW-1:0] r_pt, n_pt;
    logic [SW-1:0] r_pos, n_pos;
    logic          r_info, n_info;
    logic [1:0]    r_err, n_err;

    logic          hdr_active;
    logic          is_ver;
    logic          is_digit;
    logic [SW-1:0] pt_inc;
    logic [8:0]    foot_sum;
    logic [33:0]   skip_full;
    logic [SUMW-1:0] sum_full;
    logic [SW-1:0] pt_full;
    logic [WW-1:0] pt_wide;

    // identifier compare, ends early where both bytes are zero
    function automatic logic ident_ok(input logic [31:0] exp_id, input logic [31:0] got_id);
        logic ok;
        logic stop;
        ok   = 1'b1;
        stop = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if (!stop) begin
                if (exp_id[8*k +: 8] != got_id[8*k +: 8]) begin
                    ok   = 1'b0;
                    stop = 1'b1;
                end else if (exp_id[8*k +: 8] == 8'd0) begin
                    stop = 1'b1;
                end
            end
        end
        return ok;
    endfunction

    assign hdr_active = (r_err == fps_pkg::ERR_NONE) && !r_all;
    assign is_ver     = (r_pos >= SW'(fps_pkg::VER_FIRST)) && (r_pos <= SW'(fps_pkg::VER_LAST));
    assign is_digit   = (i_byte >= fps_pkg::ASCII_0) && (i_byte <= fps_pkg::ASCII_9);
    assign pt_inc     = (r_pt == SIZE_MAX) ? r_pt : r_pt + SW'(1);

    // segment skip and new total: 16 + length is prepared one byte earlier
    assign foot_sum  = {1'b0, i_cfg.footer} + (r_mac ? {1'b0, i_cfg.mac_ext} : 9'd0);
    assign skip_full = {1'b0, r_len16} + 34'(foot_sum);
    assign sum_full  = SUMW'(r_pt) + SUMW'(skip_full) + SUMW'(1);
    assign pt_full   = (sum_full > SUMW'(SIZE_MAX)) ? SIZE_MAX : sum_full[SW-1:0];

    always_comb begin
        n_skip   = r_skip;
        n_idx    = r_idx;
        n_ident  = r_ident;
        n_length = r_length;
        n_cur    = r_cur;
        n_tot    = r_tot;
        n_mac    = r_mac;
        n_len16  = r_len16;
        n_seen   = r_seen;
        n_all    = r_all;
        n_pt     = r_pt;
        n_err    = r_err;
        n_info   = r_info;
        n_pos    = (r_pos == SIZE_MAX) ? r_pos : r_pos + SW'(1);

        if (hdr_active) begin
            if (r_skip != 34'd0) begin
                n_skip = r_skip - 34'd1;
            end else begin
                n_pt  = pt_inc;
                n_idx = r_idx + 5'd1;
                if (r_idx < fps_pkg::HDR_IDX_LEN) begin
                    n_ident[{r_idx[1:0], 3'b000} +: 8] = i_byte;
                end else if (r_idx < fps_pkg::HDR_IDX_CUR) begin
                    n_length[{r_idx[1:0], 3'b000} +: 8] = i_byte;
                end else if (r_idx < fps_pkg::HDR_IDX_TOT) begin
                    n_cur[{r_idx[0], 3'b000} +: 8] = i_byte;
                end else if (r_idx < fps_pkg::HDR_IDX_END) begin
                    n_tot[{r_idx[0], 3'b000} +: 8] = i_byte;
                end else if (r_idx == fps_pkg::HDR_IDX_MAC) begin
                    n_mac = i_byte[0];
                end else if (r_idx == fps_pkg::HDR_IDX_PRE) begin
                    n_len16 = 33'(r_length) + 33'(fps_pkg::HDR_LEN);
                end else if (r_idx == fps_pkg::HDR_IDX_LAST) begin
                    if (!ident_ok(i_cfg.ident, r_ident)) begin
                        n_err = fps_pkg::ERR_IDENT;
                    end else if ({1'b0, r_cur} != ({1'b0, r_seen} + 17'd1)) begin
                        n_err = fps_pkg::ERR_SEQ;
                    end else begin
                        n_seen = r_seen + 16'd1;
                        n_all  = (r_cur == r_tot);
                        n_skip = skip_full;
                        n_pt   = pt_full;
                        n_idx  = 5'd0;
                    end
                end
            end
        end

        if ((n_err == fps_pkg::ERR_NONE) && is_ver && !is_digit) begin
            n_err = fps_pkg::ERR_VER;
        end

        if (!r_info && (r_pos >= n_pt)) begin
            n_info = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip   <= '0;
            r_idx    <= '0;
            r_ident  <= '0;
            r_length <= '0;
            r_cur    <= '0;
            r_tot    <= '0;
            r_mac    <= 1'b0;
            r_seen   <= '0;
            r_all    <= 1'b0;
            r_pt     <= '0;
            r_pos    <= '0;
            r_info   <= 1'b0;
            r_err    <= fps_pkg::ERR_NONE;
        end else if (i_accept) begin
            r_skip   <= n_skip;
            r_idx    <= n_idx;
            r_ident  <= n_ident;
            r_length <= n_length;
            r_cur    <= n_cur;
            r_tot    <= n_tot;
            r_mac    <= n_mac;
            r_seen   <= n_seen;
            r_all    <= n_all;
            r_pt     <= n_pt;
            r_pos    <= n_pos;
            r_info   <= n_info;
            r_err    <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_len16 <= n_len16;
        end
    end

    assign pt_wide = WW'(n_pt);

    always_comb begin
        o_result.data_out        = i_byte;
        o_result.to_info_file    = n_info;
        o_result.status          = n_err;
        o_result.is_version_char = is_ver;
        o_result.headers_done    = n_all;
        o_result.package_size    = (pt_wide > WW'(OUT_MAX)) ? OUT_MAX : pt_wide[OW-1:0];
    end

endmodule

>>> rtl/core/fps_fifo.sv
module fps_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  fps_pkg::t_result i_wdata,
    input  logic             i_rd,
    output fps_pkg::t_result o_rdata,
    output logic             o_full,
    output logic             o_empty
);

    fps_pkg::t_result r_mem [fps_pkg::FIFO_DEPTH];

    logic [fps_pkg::FIFO_PTR_W-1:0] r_wr_ptr;
    logic [fps_pkg::FIFO_PTR_W-1:0] r_rd_ptr;
    logic [fps_pkg::FIFO_CNT_W-1:0] r_count;
    logic                           wr_en;
    logic                           rd_en;

    assign o_full  = (r_count == fps_pkg::FIFO_CNT_W'(fps_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + fps_pkg::FIFO_PTR_W'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + fps_pkg::FIFO_PTR_W'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + fps_pkg::FIFO_CNT_W'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - fps_pkg::FIFO_CNT_W'(1);
            end
        end
    end

endmodule
